// ===== rtl/bf3_pkg.sv =====
// Shared types, constants and the reciprocal table of the 3x3 box filter.
// Used by the controller, the datapath and the top level; depends on nothing.
package bf3_pkg;

  localparam int SIDE_BITS        = 11;
  localparam int SIDE_RESET       = 64;
  localparam int MAX_SIDE_DEF     = 1024;
  localparam int CHANNEL_BITS_DEF = 16;
  localparam int OUT_COORD_BITS   = 10;
  localparam int CFG_ADDR_BITS    = 3;
  localparam int CFG_DATA_BITS    = 32;
  localparam int RECIP_SHIFT      = 24;
  localparam int RECIP_BITS       = 25;
  localparam int CNT_BITS         = 4;

  localparam logic REG_FRAME_SIDE = 1'b0;

  typedef struct packed {
    logic start;
    logic win_load;
    logic sum_en;
    logic tot_en;
    logic mul_en;
    logic out_load;
  } bf3_cmd_t;

  typedef struct packed {
    logic pending;
    logic last;
    logic out_free;
  } bf3_status_t;

  // ceil(2^24 / d): exact floor division for sums below 2^20
  function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] cnt);
    logic [RECIP_BITS-1:0] val;
    case (cnt)
      4'd2:    val = 25'd8388608;
      4'd3:    val = 25'd5592406;
      4'd4:    val = 25'd4194304;
      4'd5:    val = 25'd3355444;
      4'd6:    val = 25'd2796203;
      4'd7:    val = 25'd2396746;
      4'd8:    val = 25'd2097152;
      4'd9:    val = 25'd1864136;
      default: val = 25'd16777216;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/bf3_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module bf3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bf3_ctrl.sv =====
// Sequencer of the 3x3 box filter: takes one request, then steps the datapath
// through window load, row sums, total, scaling and output. Uses bf3_pkg.
module bf3_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bf3_pkg::bf3_status_t status,
  output bf3_pkg::bf3_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_ROW  = 3'd2;
  localparam logic [2:0] S_TOT  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.win_load = 1'b1;
        state_nxt    = status.pending ? S_ROW : S_IDLE;
      end
      S_ROW: begin
        cmd.sum_en = 1'b1;
        state_nxt  = S_TOT;
      end
      S_TOT: begin
        cmd.tot_en = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = status.last ? S_IDLE : S_ROW;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/bf3_datapath.sv =====
// Datapath of the 3x3 box filter: position counters, two row stores, window,
// clipped sums, reciprocal scaling and output register. Uses bf3_pkg, bf3_ram.
module bf3_datapath #(
  parameter int MAX_SIDE     = bf3_pkg::MAX_SIDE_DEF,
  parameter int CHANNEL_BITS = bf3_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bf3_pkg::bf3_cmd_t                   cmd,
  output bf3_pkg::bf3_status_t                status,
  input  logic [$clog2(MAX_SIDE)-1:0]         side_last,
  input  logic                                cnt_clear,
  input  logic [CHANNEL_BITS-1:0]             in_red,
  input  logic [CHANNEL_BITS-1:0]             in_green,
  input  logic [CHANNEL_BITS-1:0]             in_blue,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [CHANNEL_BITS-1:0]             out_red,
  output logic [CHANNEL_BITS-1:0]             out_green,
  output logic [CHANNEL_BITS-1:0]             out_blue,
  output logic [bf3_pkg::OUT_COORD_BITS-1:0]  out_row,
  output logic [bf3_pkg::OUT_COORD_BITS-1:0]  out_col,
  output logic                                out_run_last,
  output logic                                out_frame_done
);

  localparam int COORD_W = $clog2(MAX_SIDE);
  localparam int CB      = CHANNEL_BITS;
  localparam int PIX_W   = 3 * CB;
  localparam int RSUM_W  = CB + 2;
  localparam int SUM_W   = CB + 4;
  localparam int PROD_W  = SUM_W + bf3_pkg::RECIP_BITS;
  localparam int CE_W    = (COORD_W > bf3_pkg::OUT_COORD_BITS) ? COORD_W
                                                               : bf3_pkg::OUT_COORD_BITS;

  logic [COORD_W-1:0] row_cnt_r, col_cnt_r;
  logic [COORD_W-1:0] cur_row_r, cur_col_r;
  logic [COORD_W-1:0] row_in, col_in;
  logic [PIX_W-1:0]   px_r;
  logic [3:0]         pend_r;
  logic               r_ge1_r, r_ge2_r, c_ge1_r, c_ge2_r;
  logic [PIX_W-1:0]   win_r [3][3];
  logic [PIX_W-1:0]   older_q, newer_q;

  logic [1:0]         slot;
  logic [3:0]         slot_hot;
  logic [2:0]         row_ok, col_ok;
  logic [1:0]         n_rows, n_cols;
  logic [RSUM_W-1:0]  rsum_nxt [3][3];
  logic [RSUM_W-1:0]  rsum_r   [3][3];
  logic [bf3_pkg::CNT_BITS-1:0] cnt_r;
  logic [SUM_W-1:0]   sum_r  [3];
  logic [PROD_W-1:0]  prod_r [3];
  logic [COORD_W-1:0] res_row, res_col;
  logic [CE_W-1:0]    res_row_ext, res_col_ext;
  logic               out_valid_r;

  // wrap a stale position back to the frame origin
  always_comb begin
    if ((row_cnt_r > side_last) || (col_cnt_r > side_last)) begin
      row_in = '0;
      col_in = '0;
    end else begin
      row_in = row_cnt_r;
      col_in = col_cnt_r;
    end
  end

  bf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SIDE)) u_older (
    .clk   (clk),
    .we    (cmd.win_load),
    .waddr (cur_col_r),
    .wdata (newer_q),
    .re    (cmd.start),
    .raddr (col_in),
    .rdata (older_q)
  );

  bf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SIDE)) u_newer (
    .clk   (clk),
    .we    (cmd.win_load),
    .waddr (cur_col_r),
    .wdata (px_r),
    .re    (cmd.start),
    .raddr (col_in),
    .rdata (newer_q)
  );

  // lowest pending result first
  always_comb begin
    if (pend_r[0])      slot = 2'd0;
    else if (pend_r[1]) slot = 2'd1;
    else if (pend_r[2]) slot = 2'd2;
    else                slot = 2'd3;
    slot_hot  = 4'b0001 << slot;
    row_ok[0] = !slot[1] && r_ge2_r;
    row_ok[1] = r_ge1_r;
    row_ok[2] = 1'b1;
    col_ok[0] = !slot[0] && c_ge2_r;
    col_ok[1] = c_ge1_r;
    col_ok[2] = 1'b1;
    n_rows = {1'b0, row_ok[0]} + {1'b0, row_ok[1]} + {1'b0, row_ok[2]};
    n_cols = {1'b0, col_ok[0]} + {1'b0, col_ok[1]} + {1'b0, col_ok[2]};
    res_row = slot[1] ? cur_row_r : cur_row_r - COORD_W'(1);
    res_col = slot[0] ? cur_col_r : cur_col_r - COORD_W'(1);
    res_row_ext = CE_W'(res_row);
    res_col_ext = CE_W'(res_col);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int ch = 0; ch < 3; ch++) begin
        rsum_nxt[k][ch] = '0;
        for (int m = 0; m < 3; m++) begin
          if (row_ok[k] && col_ok[m]) begin
            rsum_nxt[k][ch] = rsum_nxt[k][ch] + RSUM_W'(win_r[k][m][ch*CB +: CB]);
          end
        end
      end
    end
  end

  assign status.pending  = |pend_r;
  assign status.last     = ((pend_r & ~slot_hot) == 4'b0000);
  assign status.out_free = !out_valid_r || !out_stall;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r   <= '0;
      col_cnt_r   <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cnt_clear) begin
        row_cnt_r <= '0;
        col_cnt_r <= '0;
      end else if (cmd.win_load) begin
        if (cur_col_r == side_last) begin
          col_cnt_r <= '0;
          row_cnt_r <= (cur_row_r == side_last) ? '0 : cur_row_r + COORD_W'(1);
        end else begin
          col_cnt_r <= cur_col_r + COORD_W'(1);
          row_cnt_r <= cur_row_r;
        end
      end
      if (cmd.start) begin
        pend_r[0] <= (row_in != '0) && (col_in != '0);
        pend_r[1] <= (row_in != '0) && (col_in == side_last);
        pend_r[2] <= (row_in == side_last) && (col_in != '0);
        pend_r[3] <= (row_in == side_last) && (col_in == side_last);
      end else if (cmd.out_load) begin
        pend_r <= pend_r & ~slot_hot;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_row_r <= row_in;
      cur_col_r <= col_in;
      r_ge1_r   <= (row_in != '0);
      r_ge2_r   <= (row_in > COORD_W'(1));
      c_ge1_r   <= (col_in != '0);
      c_ge2_r   <= (col_in > COORD_W'(1));
      px_r      <= {in_blue, in_green, in_red};
    end
    if (cmd.win_load) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= older_q;
      win_r[1][2] <= newer_q;
      win_r[2][2] <= px_r;
    end
    if (cmd.sum_en) begin
      rsum_r <= rsum_nxt;
      cnt_r  <= bf3_pkg::CNT_BITS'(n_rows) * bf3_pkg::CNT_BITS'(n_cols);
    end
    if (cmd.tot_en) begin
      for (int ch = 0; ch < 3; ch++) begin
        sum_r[ch] <= SUM_W'(rsum_r[0][ch]) + SUM_W'(rsum_r[1][ch]) + SUM_W'(rsum_r[2][ch]);
      end
    end
    if (cmd.mul_en) begin
      for (int ch = 0; ch < 3; ch++) begin
        prod_r[ch] <= PROD_W'(sum_r[ch]) * PROD_W'(bf3_pkg::recip(cnt_r));
      end
    end
    if (cmd.out_load) begin
      out_red        <= prod_r[0][bf3_pkg::RECIP_SHIFT +: CB];
      out_green      <= prod_r[1][bf3_pkg::RECIP_SHIFT +: CB];
      out_blue       <= prod_r[2][bf3_pkg::RECIP_SHIFT +: CB];
      out_row        <= res_row_ext[bf3_pkg::OUT_COORD_BITS-1:0];
      out_col        <= res_col_ext[bf3_pkg::OUT_COORD_BITS-1:0];
      out_run_last   <= status.last;
      out_frame_done <= (slot == 2'd3);
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/box_filter_3x3_smooth_core.sv =====
// 3x3 box smoothing filter, clipped at borders, over a square RGB frame.
// Sequence: an accepted request loads the window, then each result it causes (0 to 4)
//   passes row sums, total, scale and output; in_stall holds new requests until the
//   last result is loaded into the output register, which out_stall can hold back.
// Reset: synchronous, active low; clears sequencer, counters, frame_side to
//   64; row stores are not cleared. Uses bf3_pkg, bf3_ctrl, bf3_datapath.
module box_filter_3x3_smooth_core #(
  parameter int MAX_SIDE     = bf3_pkg::MAX_SIDE_DEF,
  parameter int CHANNEL_BITS = bf3_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bf3_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [bf3_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [bf3_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [CHANNEL_BITS-1:0]             in_red,
  input  logic [CHANNEL_BITS-1:0]             in_green,
  input  logic [CHANNEL_BITS-1:0]             in_blue,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [CHANNEL_BITS-1:0]             out_red,
  output logic [CHANNEL_BITS-1:0]             out_green,
  output logic [CHANNEL_BITS-1:0]             out_blue,
  output logic [bf3_pkg::OUT_COORD_BITS-1:0]  out_row,
  output logic [bf3_pkg::OUT_COORD_BITS-1:0]  out_col,
  output logic                                out_run_last,
  output logic                                out_frame_done
);

  localparam int COORD_W = $clog2(MAX_SIDE);
  localparam int NW      = (COORD_W + 1 > bf3_pkg::SIDE_BITS) ? COORD_W + 1
                                                              : bf3_pkg::SIDE_BITS;

  logic [bf3_pkg::SIDE_BITS-1:0] side_r;
  logic                          side_we;
  logic [NW-1:0]                 side_ext, side_eff, side_max, side_last_full;
  logic [COORD_W-1:0]            side_last;
  bf3_pkg::bf3_cmd_t             cmd;
  bf3_pkg::bf3_status_t          status;

  assign pready  = 1'b1;
  assign side_we = psel && penable && pwrite && pready
                   && (paddr[2] == bf3_pkg::REG_FRAME_SIDE);
  assign prdata  = (paddr[2] == bf3_pkg::REG_FRAME_SIDE)
                   ? bf3_pkg::CFG_DATA_BITS'(side_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= bf3_pkg::SIDE_BITS'(bf3_pkg::SIDE_RESET);
    end else if (side_we) begin
      side_r <= pwdata[bf3_pkg::SIDE_BITS-1:0];
    end
  end

  // clamp the side to 1..MAX_SIDE
  always_comb begin
    side_ext = NW'(side_r);
    side_max = NW'(MAX_SIDE);
    if (side_ext == '0) begin
      side_eff = NW'(1);
    end else if (side_ext > side_max) begin
      side_eff = side_max;
    end else begin
      side_eff = side_ext;
    end
    side_last_full = side_eff - NW'(1);
    side_last      = side_last_full[COORD_W-1:0];
  end

  bf3_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bf3_datapath #(
    .MAX_SIDE     (MAX_SIDE),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .side_last      (side_last),
    .cnt_clear      (side_we),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_run_last   (out_run_last),
    .out_frame_done (out_frame_done)
  );

endmodule

// ===== tb/sv/box_filter_3x3_smooth_core_tb.sv =====
// Self-checking testbench for the 3x3 clipped box smoothing core: raster pixel
// requests in, smoothed pixels with coordinates out, checked against a local model.
// Depends on bf3_pkg and box_filter_3x3_smooth_core.
module box_filter_3x3_smooth_core_tb;

  localparam int MAX_SIDE    = bf3_pkg::MAX_SIDE_DEF;
  localparam int CH_BITS     = bf3_pkg::CHANNEL_BITS_DEF;
  localparam int ADDR_W      = bf3_pkg::CFG_ADDR_BITS;
  localparam int DATA_W      = bf3_pkg::CFG_DATA_BITS;
  localparam int COORD_BITS  = bf3_pkg::OUT_COORD_BITS;
  localparam int SIDE_W      = bf3_pkg::SIDE_BITS;
  localparam int SETTLE      = 20;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [ADDR_W-1:0] SIDE_ADDR = ADDR_W'(4 * int'(bf3_pkg::REG_FRAME_SIDE));

  typedef logic [CH_BITS-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  typedef struct packed {
    chan_t                 red;
    chan_t                 green;
    chan_t                 blue;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic                  run_last;
    logic                  frame_done;
  } smooth_t;

  typedef struct packed {
    logic        write_cfg;
    logic [31:0] cfg_value;
    pixel_t      px;
    logic        typed;
    smooth_t     golden;
  } stim_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [ADDR_W-1:0]        paddr;
  logic [DATA_W-1:0]        pwdata;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;
  logic                     in_valid;
  logic                     in_stall;
  chan_t                    in_red;
  chan_t                    in_green;
  chan_t                    in_blue;
  logic                     out_valid;
  logic                     out_stall;
  chan_t                    out_red;
  chan_t                    out_green;
  chan_t                    out_blue;
  logic [COORD_BITS-1:0]    out_row;
  logic [COORD_BITS-1:0]    out_col;
  logic                     out_run_last;
  logic                     out_frame_done;

  box_filter_3x3_smooth_core #(
    .MAX_SIDE     (MAX_SIDE),
    .CHANNEL_BITS (CH_BITS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_run_last   (out_run_last),
    .out_frame_done (out_frame_done)
  );

  smooth_t   pending_means[$];
  stim_row_t directed_rows[$];

  pixel_t            older_line[MAX_SIDE];
  pixel_t            newer_line[MAX_SIDE];
  pixel_t            win[3][3];
  int                next_row;
  int                next_col;
  logic [SIDE_W-1:0] side_reg;

  int src_idle_pct;
  int sink_stall_pct;
  int error_count;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int frame_side_now();
    int s;
    s = int'(side_reg);
    if (s == 0) s = 1;
    if (s > MAX_SIDE) s = MAX_SIDE;
    return s;
  endfunction

  function automatic smooth_t window_mean(int r, int c, int tr, int tc, int n, bit last);
    int      sum_r;
    int      sum_g;
    int      sum_b;
    int      cnt;
    int      rr;
    int      cc;
    smooth_t res;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    cnt   = 0;
    for (int k = 0; k < 3; k++) begin
      rr = r - 2 + k;
      if (rr >= 0 && rr >= tr - 1 && rr <= tr + 1 && rr <= n - 1) begin
        for (int m = 0; m < 3; m++) begin
          cc = c - 2 + m;
          if (cc >= 0 && cc >= tc - 1 && cc <= tc + 1 && cc <= n - 1) begin
            sum_r += int'(win[k][m].red);
            sum_g += int'(win[k][m].green);
            sum_b += int'(win[k][m].blue);
            cnt++;
          end
        end
      end
    end
    if (cnt == 0) cnt = 1;
    res.red        = chan_t'(sum_r / cnt);
    res.green      = chan_t'(sum_g / cnt);
    res.blue       = chan_t'(sum_b / cnt);
    res.row        = COORD_BITS'(tr);
    res.col        = COORD_BITS'(tc);
    res.run_last   = last;
    res.frame_done = (tr == n - 1 && tc == n - 1);
    return res;
  endfunction

  function automatic int smooth_pixel(pixel_t px);
    int n;
    int r;
    int c;
    int cnt;
    int tr[4];
    int tc[4];
    n   = frame_side_now();
    r   = next_row;
    c   = next_col;
    cnt = 0;
    if (r >= n || c >= n) begin
      r = 0;
      c = 0;
    end
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2]     = older_line[c];
    win[1][2]     = newer_line[c];
    win[2][2]     = px;
    older_line[c] = newer_line[c];
    newer_line[c] = px;
    if (r >= 1 && c >= 1) begin
      tr[cnt] = r - 1; tc[cnt] = c - 1; cnt++;
    end
    if (r >= 1 && c == n - 1) begin
      tr[cnt] = r - 1; tc[cnt] = c; cnt++;
    end
    if (r == n - 1 && c >= 1) begin
      tr[cnt] = r; tc[cnt] = c - 1; cnt++;
    end
    if (r == n - 1 && c == n - 1) begin
      tr[cnt] = r; tc[cnt] = c; cnt++;
    end
    for (int k = 0; k < cnt; k++)
      pending_means.push_back(window_mean(r, c, tr[k], tc[k], n, k == cnt - 1));
    c++;
    if (c >= n) begin
      c = 0;
      r++;
      if (r >= n) r = 0;
    end
    next_row = r;
    next_col = c;
    return cnt;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    chan_t  ch[3];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(7))
        0:       ch[i] = '0;
        1:       ch[i] = '1;
        default: ch[i] = chan_t'($urandom);
      endcase
    end
    px.red   = ch[0];
    px.green = ch[1];
    px.blue  = ch[2];
    return px;
  endfunction

  function automatic void add_row(bit write_cfg, int side, chan_t r, chan_t g, chan_t b,
                                  bit typed);
    stim_row_t row;
    row.write_cfg = write_cfg;
    row.cfg_value = 32'(side);
    row.px        = '{r, g, b};
    row.typed     = typed;
    row.golden    = '{r, g, b, '0, '0, 1'b1, 1'b1};
    directed_rows.push_back(row);
  endfunction

  task automatic report(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t %s: expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic send_pixel(input pixel_t px, input bit typed, input smooth_t golden);
    int produced;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_red   = px.red;
    in_green = px.green;
    in_blue  = px.blue;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    produced = smooth_pixel(px);
    if (typed && produced == 1) begin
      void'(pending_means.pop_back());
      pending_means.push_back(golden);
    end
  endtask

  task automatic drain(input int settle);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_side(input logic [31:0] value);
    logic [31:0] rd;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = SIDE_ADDR;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    side_reg = value[SIDE_W-1:0];
    next_row = 0;
    next_col = 0;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    report("frame_side readback", 32'(value[SIDE_W-1:0]), 32'(rd[SIDE_W-1:0]));
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk) begin
    smooth_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_means.size() == 0) begin
        error_count++;
        $display("%0t unexpected result: expected none actual row %0d col %0d",
                 $time, out_row, out_col);
      end else begin
        want = pending_means.pop_front();
        report("out_red", 32'(want.red), 32'(out_red));
        report("out_green", 32'(want.green), 32'(out_green));
        report("out_blue", 32'(want.blue), 32'(out_blue));
        report("out_row", 32'(want.row), 32'(out_row));
        report("out_col", 32'(want.col), 32'(out_col));
        report("out_run_last", 32'(want.run_last), 32'(out_run_last));
        report("out_frame_done", 32'(want.frame_done), 32'(out_frame_done));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("box_filter_3x3_smooth_core_tb: errors");
      $finish;
    end
  end

  initial begin
    int        side;
    int        count;
    int        frame_px;
    stim_row_t row;
    int        src_modes[4];
    int        sink_modes[4];

    src_modes  = '{0, 85, 0, 19};
    sink_modes = '{0, 0, 85, 19};

    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    in_red         = '0;
    in_green       = '0;
    in_blue        = '0;
    out_stall      = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    error_count    = 0;
    cycle_count    = 0;
    side_reg       = SIDE_W'(bf3_pkg::SIDE_RESET);
    next_row       = 0;
    next_col       = 0;
    for (int i = 0; i < MAX_SIDE; i++) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    for (int k = 0; k < 3; k++)
      for (int m = 0; m < 3; m++)
        win[k][m] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // default side after reset, then restart the frame mid-row
    add_row(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    add_row(0, 0, 16'h0000, 16'h0000, 16'h0000, 0);
    add_row(0, 0, 16'h8000, 16'h7FFF, 16'h0001, 0);
    add_row(1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
    add_row(0, 0, 16'h0000, 16'h0000, 16'h0000, 1);
    add_row(0, 0, 16'h5555, 16'hAAAA, 16'h1234, 1);
    // side zero behaves as side one
    add_row(1, 0, 16'hAAAA, 16'h5555, 16'hFFFF, 1);
    add_row(0, 0, 16'hFEDC, 16'h0000, 16'h8001, 1);
    // two-pixel side: last pixel releases four results
    add_row(1, 2, 16'h0001, 16'hFFFF, 16'h8000, 0);
    add_row(0, 0, 16'hFFFF, 16'hFFFF, 16'h7FFF, 0);
    add_row(0, 0, 16'h8000, 16'h0001, 16'hFFFF, 0);
    add_row(0, 0, 16'h7FFF, 16'hFFFE, 16'h0000, 0);
    // three-pixel side: corners, edges and the full window, then wrap
    add_row(1, 3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    add_row(0, 0, 16'hFFFF, 16'h0000, 16'h1111, 0);
    add_row(0, 0, 16'h0000, 16'hFFFF, 16'h2222, 0);
    add_row(0, 0, 16'hFFFF, 16'hFFFF, 16'h3333, 0);
    add_row(0, 0, 16'hFFFF, 16'hFFFF, 16'h4444, 0);
    add_row(0, 0, 16'h0007, 16'hFFFF, 16'h5555, 0);
    add_row(0, 0, 16'hFFFF, 16'h0003, 16'h6666, 0);
    add_row(0, 0, 16'hFFFF, 16'hFFFF, 16'h7777, 0);
    add_row(0, 0, 16'hFFFF, 16'hFFFF, 16'h8888, 0);
    add_row(0, 0, 16'h1234, 16'h5678, 16'h9ABC, 0);
    add_row(0, 0, 16'hDEF0, 16'h0FED, 16'hCBA9, 0);
    add_row(0, 0, 16'h8765, 16'h4321, 16'h0000, 0);

    src_idle_pct   = 19;
    sink_stall_pct = 19;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.write_cfg) begin
        drain(SETTLE);
        write_side(row.cfg_value);
      end
      send_pixel(row.px, row.typed, row.golden);
    end

    for (int seg = 0; seg < 8; seg++) begin
      side     = $urandom_range(1, 7);
      frame_px = side * side;
      if ($urandom_range(3) == 0)
        count = $urandom_range(5, 40);
      else
        count = frame_px * ((20 + frame_px - 1) / frame_px);
      drain(SETTLE);
      write_side(32'(side));
      src_idle_pct   = src_modes[seg / 2];
      sink_stall_pct = sink_modes[seg / 2];
      for (int i = 0; i < count; i++) begin
        if (seg == 2 && i == count / 2) begin
          // hold requests until every smoothed pixel is out
          @(negedge clk);
          in_valid = 1'b0;
          while (pending_means.size() != 0) @(posedge clk);
        end
        send_pixel(random_pixel(), 1'b0, '0);
      end
    end

    // widest frame, written exactly and as an oversized value
    drain(SETTLE);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    write_side(32'(MAX_SIDE));
    for (int i = 0; i < 20; i++)
      send_pixel(random_pixel(), 1'b0, '0);
    drain(SETTLE);
    write_side(32'h7FF);
    for (int i = 0; i < 20; i++)
      send_pixel(random_pixel(), 1'b0, '0);

    drain(SETTLE);
    if (error_count == 0)
      $display("box_filter_3x3_smooth_core_tb: clean");
    else
      $display("box_filter_3x3_smooth_core_tb: errors");
    $finish;
  end

endmodule
